@@ rtl/core/dq_pkg.sv @@
package dq_pkg;

  // field widths
  localparam int unsigned KindW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 7;

  // default number of entries
  localparam int unsigned DepthDef = 64;

  // operation codes
  localparam logic [KindW-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [KindW-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [KindW-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [KindW-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [KindW-1:0] OP_PEEK_FRONT = 3'd4;

  // status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  // broadcast control for every cell of the chain
  typedef struct packed {
    logic              a_shr;  // front chain: move toward the tail end
    logic              a_shl;  // front chain: move toward cell 0
    logic              a_far;  // front chain: write value at the cell at count
    logic              b_shr;  // back chain: move toward the tail end
    logic              b_shl;  // back chain: move toward cell 0
    logic              b_far;  // back chain: write value at the cell at count
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/core/dq_cell.sv @@
module dq_cell (
  input  logic                          clk_i,
  input  dq_pkg::cell_ctrl_t            ctrl_i,
  input  logic                          far_i,
  input  logic [dq_pkg::ValueW-1:0]     a_left_i,
  input  logic [dq_pkg::ValueW-1:0]     a_right_i,
  input  logic [dq_pkg::ValueW-1:0]     b_left_i,
  input  logic [dq_pkg::ValueW-1:0]     b_right_i,
  output logic [dq_pkg::ValueW-1:0]     a_o,
  output logic [dq_pkg::ValueW-1:0]     b_o
);

  logic [dq_pkg::ValueW-1:0] a_q, a_d;
  logic [dq_pkg::ValueW-1:0] b_q, b_d;

  always_comb begin
    a_d = a_q;
    if (ctrl_i.a_shr) begin
      a_d = a_left_i;
    end else if (ctrl_i.a_shl) begin
      a_d = a_right_i;
    end else if (ctrl_i.a_far && far_i) begin
      a_d = ctrl_i.value;
    end
  end

  always_comb begin
    b_d = b_q;
    if (ctrl_i.b_shr) begin
      b_d = b_left_i;
    end else if (ctrl_i.b_shl) begin
      b_d = b_right_i;
    end else if (ctrl_i.b_far && far_i) begin
      b_d = ctrl_i.value;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

@@ rtl/core/double_ended_queue.sv @@
// channel   ports                                          dir  transfer when
// command   start_i, kind_i, push_value_i                  in   start_i & !busy_o
// result    done_o, read_value_o, status_o, occupancy_o    out  done_o (one cycle)
//
// one operation per cycle; the result strobes on done_o the cycle after start_i
// latency is set by the single register stage after the cell chain
// busy_o stays low: every operation finishes in the cycle it is taken
// rst_ni clears the entry count and the result strobe; cell contents are don't care
// results cannot be held off, so nothing in the block ever stalls
module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [dq_pkg::KindW-1:0]          kind_i,
  input  logic signed [dq_pkg::ValueW-1:0]  push_value_i,
  output logic                              done_o,
  output logic signed [dq_pkg::ValueW-1:0]  read_value_o,
  output logic [dq_pkg::StatusW-1:0]        status_o,
  output logic [dq_pkg::OccW-1:0]           occupancy_o
);

  // count must hold DEPTH itself
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // two copies of the contents ride in the same row of cells:
  //   chain a keeps the front entry in cell 0 and grows toward the tail
  //   chain b keeps the back entry in cell 0 and grows toward the tail
  // so both ends are always read at cell 0 and a push to the far end of a
  // chain is a write at the cell whose position equals the count
  logic [DEPTH-1:0][dq_pkg::ValueW-1:0] a_val;
  logic [DEPTH-1:0][dq_pkg::ValueW-1:0] b_val;
  logic [DEPTH-1:0]                     far;

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  logic [dq_pkg::ValueW-1:0]  read_value_q, read_value_d;
  logic [dq_pkg::StatusW-1:0] status_q, status_d;

  dq_pkg::cell_ctrl_t ctrl;

  logic fire;
  logic is_empty;
  logic is_full;

  assign busy_o   = 1'b0;
  assign fire     = start_i & ~busy_o;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(DEPTH));

  // operation decode
  always_comb begin
    ctrl         = '0;
    ctrl.value   = push_value_i;
    count_d      = count_q;
    read_value_d = '0;
    status_d     = dq_pkg::ST_OK;
    if (fire) begin
      unique case (kind_i)
        dq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            status_d = dq_pkg::ST_FULL;
          end else begin
            // new front: insert at cell 0 of a, append at the far end of b
            ctrl.a_shr = 1'b1;
            ctrl.b_far = 1'b1;
            count_d    = count_q + CntW'(1);
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            status_d = dq_pkg::ST_FULL;
          end else begin
            ctrl.b_shr = 1'b1;
            ctrl.a_far = 1'b1;
            count_d    = count_q + CntW'(1);
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            status_d = dq_pkg::ST_EMPTY;
          end else begin
            // b just loses its far entry through the count
            read_value_d = a_val[0];
            ctrl.a_shl   = 1'b1;
            count_d      = count_q - CntW'(1);
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (is_empty) begin
            status_d = dq_pkg::ST_EMPTY;
          end else begin
            read_value_d = b_val[0];
            ctrl.b_shl   = 1'b1;
            count_d      = count_q - CntW'(1);
          end
        end
        dq_pkg::OP_PEEK_FRONT: begin
          if (is_empty) begin
            status_d = dq_pkg::ST_EMPTY;
          end else begin
            read_value_d = a_val[0];
          end
        end
        default: begin
          // unused kinds leave everything as it is
        end
      endcase
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [dq_pkg::ValueW-1:0] a_left, a_right, b_left, b_right;

    // each cell sees whether it sits right past the last held entry
    assign far[i] = (count_q == CntW'(i));

    if (i == 0) begin : g_head
      assign a_left = push_value_i;
      assign b_left = push_value_i;
    end else begin : g_body
      assign a_left = a_val[i-1];
      assign b_left = b_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign a_right = '0;
      assign b_right = '0;
    end else begin : g_inner
      assign a_right = a_val[i+1];
      assign b_right = b_val[i+1];
    end

    dq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .far_i     (far[i]),
      .a_left_i  (a_left),
      .a_right_i (a_right),
      .b_left_i  (b_left),
      .b_right_i (b_right),
      .a_o       (a_val[i]),
      .b_o       (b_val[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= fire;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_value_q <= read_value_d;
      status_q     <= status_d;
    end
  end

  assign done_o       = done_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  // occupancy after the operation, low bits only for deep queues
  assign occupancy_o  = dq_pkg::OccW'(count_q);

endmodule

@@ tb/double_ended_queue_test.sv @@
module double_ended_queue_test;
  import dq_pkg::*;

  localparam int unsigned Depth      = DepthDef;
  // results strobe in the cycle after the transfer; then spare cycles at the end
  localparam int unsigned TailCycles = 8;
  localparam int unsigned OpTarget   = 2000;
  localparam int unsigned MaxGap     = 13;

  // one queued command for the driver
  typedef struct {
    logic [KindW-1:0]         kind;
    logic signed [ValueW-1:0] value;
    int unsigned              gap;    // idle cycles before this command
    bit                       drain;  // hold off until every result is back
  } deque_op_t;

  // one result as seen on the result ports
  typedef struct packed {
    logic signed [ValueW-1:0] read_value;
    logic [StatusW-1:0]       status;
    logic [OccW-1:0]          occupancy;
  } deque_result_t;

  logic                      clk_i;
  logic                      rst_ni       = 1'b0;
  logic                      start_i      = 1'b0;
  logic [KindW-1:0]          kind_i       = OP_PUSH_FRONT;
  logic signed [ValueW-1:0]  push_value_i = '0;
  logic                      busy_o;
  logic                      done_o;
  logic signed [ValueW-1:0]  read_value_o;
  logic [StatusW-1:0]        status_o;
  logic [OccW-1:0]           occupancy_o;

  double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .push_value_i(push_value_i),
    .done_o      (done_o),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  // commands waiting to be driven, and results waiting to be seen
  deque_op_t     op_backlog[$];
  deque_result_t pending_results[$];

  // shadow copy of the deque contents
  logic signed [ValueW-1:0] shadow_store[Depth];
  int unsigned              shadow_front = 0;
  int unsigned              shadow_count = 0;

  int unsigned ops_total    = 0;
  int unsigned ops_accepted = 0;
  int unsigned failures     = 0;

  // driver bookkeeping
  bit          cmd_taken = 1'b0;
  bit          have_next = 1'b0;
  deque_op_t   next_op;
  int unsigned wait_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // apply one operation to the shadow deque and return what the block must report
  function automatic deque_result_t deque_apply(input logic [KindW-1:0] kind,
                                                input logic signed [ValueW-1:0] value);
    deque_result_t res;
    res.read_value = '0;
    res.status     = ST_OK;
    case (kind)
      OP_PUSH_FRONT: begin
        if (shadow_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          // front pointer steps back one slot, wrapping below zero
          shadow_front = (shadow_front + Depth - 1) % Depth;
          shadow_store[shadow_front] = value;
          shadow_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          shadow_store[(shadow_front + shadow_count) % Depth] = value;
          shadow_count++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_value = shadow_store[shadow_front];
          shadow_front   = (shadow_front + 1) % Depth;
          shadow_count--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_value = shadow_store[(shadow_front + shadow_count - 1) % Depth];
          shadow_count--;
        end
      end
      OP_PEEK_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_value = shadow_store[shadow_front];
        end
      end
      default: begin
        // spare kinds leave everything as it is
      end
    endcase
    res.occupancy = OccW'(shadow_count);
    return res;
  endfunction

  task automatic queue_op(input logic [KindW-1:0] kind, input logic signed [ValueW-1:0] value,
                          input int unsigned gap, input bit drain);
    deque_op_t op;
    op.kind  = kind;
    op.value = value;
    op.gap   = gap;
    op.drain = drain;
    op_backlog.push_back(op);
  endtask

  // extremes show up often, the rest is uniform over all 32 bits
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [KindW-1:0] pick_spare_kind();
    return OP_PEEK_FRONT + KindW'($urandom_range(1, 3));
  endfunction

  // driver: a command moves on once the previous transfer has happened
  always @(negedge clk_i) begin : driver
    bit go;
    go = 1'b0;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && !cmd_taken)) begin
      if (!have_next && op_backlog.size() > 0) begin
        next_op   = op_backlog.pop_front();
        have_next = 1'b1;
        wait_left = next_op.gap;
      end
      if (have_next) begin
        if (wait_left > 0) begin
          wait_left--;
        end else if (!(next_op.drain && pending_results.size() > 0)) begin
          // a drain command waits for the deque's last result before going out
          go           = 1'b1;
          have_next    = 1'b0;
          kind_i       <= next_op.kind;
          push_value_i <= next_op.value;
        end
      end
      start_i <= go;
    end
  end

  // monitor: check the result strobe first, then record the command transfer
  always @(posedge clk_i) begin : monitor
    deque_result_t want;
    if (!rst_ni) begin
      cmd_taken = 1'b0;
    end else begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: read_value %0d status %0d occupancy %0d",
                 read_value_o, status_o, occupancy_o);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (read_value_o !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, read_value_o);
            failures++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            failures++;
          end
          if (occupancy_o !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy_o);
            failures++;
          end
        end
      end
      cmd_taken = start_i && !busy_o;
      if (cmd_taken) begin
        pending_results.push_back(deque_apply(kind_i, push_value_i));
        ops_accepted++;
      end
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned phase_len;
    int unsigned phase_sort;
    int unsigned gap_mode;
    int unsigned gap;
    int unsigned roll;
    logic [KindW-1:0] kind;

    // directed: empty deque, wrap of the front pointer, extremes, spare kinds
    queue_op(OP_POP_FRONT, '0, 0, 1'b0);
    queue_op(OP_POP_BACK, '1, 0, 1'b0);
    queue_op(OP_PEEK_FRONT, '0, 2, 1'b0);
    queue_op(OP_PUSH_FRONT, 32'sh7fff_ffff, 0, 1'b0);
    queue_op(OP_PUSH_BACK, 32'sh8000_0000, 0, 1'b0);
    queue_op(OP_PEEK_FRONT, '0, 1, 1'b0);
    queue_op(OP_PUSH_FRONT, '1, 0, 1'b0);
    queue_op(OP_PUSH_BACK, '0, 3, 1'b0);
    queue_op(OP_PEEK_FRONT + KindW'(1), 32'sh5a5a_a5a5, 0, 1'b0);
    queue_op(OP_PEEK_FRONT + KindW'(2), '1, 0, 1'b0);
    queue_op(OP_PEEK_FRONT + KindW'(3), '0, 0, 1'b0);
    queue_op(OP_POP_BACK, '0, 0, 1'b0);
    queue_op(OP_POP_FRONT, '0, 0, 1'b0);
    queue_op(OP_PEEK_FRONT, '0, 0, 1'b0);
    queue_op(OP_POP_BACK, '0, 1, 1'b0);
    queue_op(OP_POP_FRONT, '0, 0, 1'b0);
    queue_op(OP_POP_BACK, '0, 0, 1'b0);
    queue_op(OP_PUSH_BACK, 32'sd1, 0, 1'b0);
    queue_op(OP_PUSH_BACK, $urandom(), 0, 1'b0);
    queue_op(OP_POP_FRONT, '0, 0, 1'b0);
    queue_op(OP_POP_FRONT, '0, 0, 1'b0);

    // run to full and past it, then back to empty and past it
    // the first of these waits for all outstanding results
    for (int i = 0; i < Depth + 6; i++) begin
      queue_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value(),
               0, i == 0);
    end
    for (int i = 0; i < Depth + 6; i++) begin
      queue_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, '0,
               (i % 9 == 0) ? $urandom_range(0, MaxGap) : 0, 1'b0);
    end

    // random phases: filling, draining or mixed, each with its own idle pattern
    counted = 0;
    while (counted < OpTarget) begin
      phase_sort = $urandom_range(0, 2);
      gap_mode   = $urandom_range(0, 2);
      phase_len  = $urandom_range(20, 150);
      for (int i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          kind = pick_spare_kind();
        end else begin
          case (phase_sort)
            0:       kind = (roll < 85) ? ($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK)
                                        : KindW'($urandom_range(2, 4));
            1:       kind = (roll < 85) ? KindW'($urandom_range(2, 4))
                                        : ($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK);
            default: kind = KindW'($urandom_range(0, 4));
          endcase
          counted++;
        end
        case (gap_mode)
          0:       gap = 0;
          1:       gap = $urandom_range(0, MaxGap);
          default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxGap) : 0;
        endcase
        queue_op(kind, pick_value(), gap, i == 0 && $urandom_range(0, 3) == 0);
      end
    end
    ops_total = op_backlog.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every command transferred and every result seen, then a quiet tail
    while (!(ops_accepted == ops_total && pending_results.size() == 0)) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (failures == 0) begin
      $display("double_ended_queue_test: PASS");
    end else begin
      $display("double_ended_queue_test: FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("double_ended_queue_test: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/dq_pkg.sv
rtl/core/dq_cell.sv
rtl/core/double_ended_queue.sv
tb/double_ended_queue_test.sv
